// ===== rtl/ocad_pkg.sv =====
// ocad_pkg: shared types and constants for the output clamp, alarm and deadband unit.
// Alarm status codes, severity codes, register indexes and the compare-width helper.
// No dependencies.
`default_nettype none

package ocad_pkg;

   localparam int LIMIT_WIDTH    = 32;
   localparam int CMP_WIDTH      = 66;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;

   typedef enum logic [2:0] {
      ST_NONE  = 3'd0,
      ST_HIHI  = 3'd1,
      ST_LOLO  = 3'd2,
      ST_HIGH  = 3'd3,
      ST_LOW   = 3'd4,
      ST_UNDEF = 3'd5
   } alarm_status_type;

   typedef logic [1:0] severity_type;

   localparam severity_type SEV_NONE    = 2'd0;
   localparam severity_type SEV_INVALID = 2'd3;

   typedef enum logic [2:0] {
      REG_DRIVE_HIGH   = 3'd0,
      REG_DRIVE_LOW    = 3'd1,
      REG_UPPER_LIMITS = 3'd2,
      REG_LOWER_LIMITS = 3'd3,
      REG_HYSTERESIS   = 3'd4,
      REG_VALUE_DB     = 3'd5,
      REG_ARCHIVE_DB   = 3'd6,
      REG_SEVERITIES   = 3'd7
   } reg_index_type;

   // clamp a widened bound into the signed 64-bit range
   function automatic logic signed [CMP_WIDTH-1:0] sat64(input logic signed [CMP_WIDTH-1:0] x);
      logic signed [CMP_WIDTH-1:0] hi;
      logic signed [CMP_WIDTH-1:0] lo;
      hi = {3'b000, {(CMP_WIDTH-3){1'b1}}};
      lo = {3'b111, {(CMP_WIDTH-3){1'b0}}};
      if (x > hi) begin
         return hi;
      end else if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/output_clamp_alarm_deadband_unit.sv =====
// A transaction accepted into the input register is presented on rsp_ once it has moved into
// the result register, which loads only when rsp_stall does not hold a presented result.
// Throughput: one transaction per cycle while no stall holds the result register, set by
// the single pass of clamp, limit compare and deadband logic. Reset: synchronous, active
// high; clears configuration registers, alarm history and last posted values to zero and empties both stages.
// output_clamp_alarm_deadband_unit: top level, APB-style register port, depends on ocad_pkg.
`default_nettype none

module output_clamp_alarm_deadband_unit
   import ocad_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [DATA_WIDTH-1:0]            req_requested_value,
   input  wire                              req_value_defined,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [DATA_WIDTH-1:0]            rsp_output_value,
   output logic [2:0]                       rsp_alarm_status,
   output logic [1:0]                       rsp_alarm_severity,
   output logic                             rsp_alarm_changed,
   output logic                             rsp_post_value_event,
   output logic                             rsp_post_archive_event,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [CSR_ADDR_WIDTH-1:0]        paddr,
   input  wire  [CSR_DATA_WIDTH-1:0]        pwdata,
   output logic [CSR_DATA_WIDTH-1:0]        prdata,
   output logic                             pready
);

   localparam int LW = (DATA_WIDTH > LIMIT_WIDTH) ? DATA_WIDTH : LIMIT_WIDTH;

   // configuration registers
   logic [DATA_WIDTH-1:0]  drive_high_ff, drive_low_ff, hyst_ff, vdb_ff, adb_ff;
   logic [63:0]            upper_ff, lower_ff;
   logic [7:0]             sev_cfg_ff;
   reg_index_type          wr_index;
   logic                   wr_en;

   // pipeline
   logic                   s1_valid_ff;
   logic [DATA_WIDTH-1:0]  s1_value_ff;
   logic                   s1_defined_ff;
   logic                   out_valid_ff;
   logic [DATA_WIDTH-1:0]  out_value_ff;
   alarm_status_type       out_status_ff;
   severity_type           out_sev_ff;
   logic                   out_changed_ff, out_pv_ff, out_pa_ff;
   logic                   out_free, s1_move;

   // item state
   logic [LW-1:0]          last_alarm_ff, last_alarm_in;
   logic [DATA_WIDTH-1:0]  last_value_ff, last_value_in;
   logic [DATA_WIDTH-1:0]  last_archive_ff, last_archive_in;
   alarm_status_type       prev_status_ff;
   severity_type           prev_sev_ff;

   // datapath
   logic [DATA_WIDTH-1:0]       val_c;
   logic signed [CMP_WIDTH-1:0] val_x, la_x, hyst_x;
   logic signed [CMP_WIDTH-1:0] hihi_x, high_x, low_x, lolo_x;
   logic signed [CMP_WIDTH-1:0] b_hihi, b_high, b_low, b_lolo;
   severity_type                s_hihi, s_lolo, s_high, s_low;
   alarm_status_type            stat_in;
   severity_type                sev_in;
   logic [DATA_WIDTH-1:0]       vdiff, vabs, adiff, aabs;
   logic                        pv_in, pa_in;

   // ---------------- register port ----------------
   assign pready   = 1'b1;
   assign wr_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:3]);
   assign wr_en    = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_high_ff <= '0;
         drive_low_ff  <= '0;
         upper_ff      <= '0;
         lower_ff      <= '0;
         hyst_ff       <= '0;
         vdb_ff        <= '0;
         adb_ff        <= '0;
         sev_cfg_ff    <= '0;
      end else if (wr_en) begin
         case (wr_index)
            REG_DRIVE_HIGH:   drive_high_ff <= pwdata[DATA_WIDTH-1:0];
            REG_DRIVE_LOW:    drive_low_ff  <= pwdata[DATA_WIDTH-1:0];
            REG_UPPER_LIMITS: upper_ff      <= pwdata[63:0];
            REG_LOWER_LIMITS: lower_ff      <= pwdata[63:0];
            REG_HYSTERESIS:   hyst_ff       <= pwdata[DATA_WIDTH-1:0];
            REG_VALUE_DB:     vdb_ff        <= pwdata[DATA_WIDTH-1:0];
            REG_ARCHIVE_DB:   adb_ff        <= pwdata[DATA_WIDTH-1:0];
            REG_SEVERITIES:   sev_cfg_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wr_index)
         REG_DRIVE_HIGH:   prdata = CSR_DATA_WIDTH'(drive_high_ff);
         REG_DRIVE_LOW:    prdata = CSR_DATA_WIDTH'(drive_low_ff);
         REG_UPPER_LIMITS: prdata = upper_ff;
         REG_LOWER_LIMITS: prdata = lower_ff;
         REG_HYSTERESIS:   prdata = CSR_DATA_WIDTH'(hyst_ff);
         REG_VALUE_DB:     prdata = CSR_DATA_WIDTH'(vdb_ff);
         REG_ARCHIVE_DB:   prdata = CSR_DATA_WIDTH'(adb_ff);
         REG_SEVERITIES:   prdata = CSR_DATA_WIDTH'(sev_cfg_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_value_ff   <= req_requested_value;
         s1_defined_ff <= req_value_defined;
      end
   end

   // ---------------- clamp ----------------
   always_comb begin
      val_c = s1_value_ff;
      if ($signed(drive_high_ff) > $signed(drive_low_ff)) begin
         if ($signed(s1_value_ff) > $signed(drive_high_ff)) begin
            val_c = drive_high_ff;
         end else if ($signed(s1_value_ff) < $signed(drive_low_ff)) begin
            val_c = drive_low_ff;
         end
      end
   end

   // ---------------- alarm classification ----------------
   assign val_x  = CMP_WIDTH'($signed(val_c));
   assign la_x   = CMP_WIDTH'($signed(last_alarm_ff));
   assign hyst_x = CMP_WIDTH'($signed(hyst_ff));
   assign hihi_x = CMP_WIDTH'($signed(upper_ff[63:32]));
   assign high_x = CMP_WIDTH'($signed(upper_ff[31:0]));
   assign low_x  = CMP_WIDTH'($signed(lower_ff[63:32]));
   assign lolo_x = CMP_WIDTH'($signed(lower_ff[31:0]));
   assign b_hihi = sat64(hihi_x - hyst_x);
   assign b_high = sat64(high_x - hyst_x);
   assign b_lolo = sat64(lolo_x + hyst_x);
   assign b_low  = sat64(low_x + hyst_x);
   assign s_hihi = sev_cfg_ff[7:6];
   assign s_lolo = sev_cfg_ff[5:4];
   assign s_high = sev_cfg_ff[3:2];
   assign s_low  = sev_cfg_ff[1:0];

   always_comb begin
      stat_in       = ST_NONE;
      sev_in        = SEV_NONE;
      last_alarm_in = last_alarm_ff;
      if (!s1_defined_ff) begin
         stat_in = ST_UNDEF;
         sev_in  = SEV_INVALID;
      end else if (s_hihi != SEV_NONE
                   && (val_x >= hihi_x || (la_x == hihi_x && val_x >= b_hihi))) begin
         stat_in       = ST_HIHI;
         sev_in        = s_hihi;
         last_alarm_in = LW'(hihi_x);
      end else if (s_lolo != SEV_NONE
                   && (val_x <= lolo_x || (la_x == lolo_x && val_x <= b_lolo))) begin
         stat_in       = ST_LOLO;
         sev_in        = s_lolo;
         last_alarm_in = LW'(lolo_x);
      end else if (s_high != SEV_NONE
                   && (val_x >= high_x || (la_x == high_x && val_x >= b_high))) begin
         stat_in       = ST_HIGH;
         sev_in        = s_high;
         last_alarm_in = LW'(high_x);
      end else if (s_low != SEV_NONE
                   && (val_x <= low_x || (la_x == low_x && val_x <= b_low))) begin
         stat_in       = ST_LOW;
         sev_in        = s_low;
         last_alarm_in = LW'(low_x);
      end else begin
         last_alarm_in = LW'(val_x);
      end
   end

   // ---------------- deadbands ----------------
   // a wrapped difference of exactly half the range is above any band
   assign vdiff = last_value_ff - val_c;
   assign vabs  = vdiff[DATA_WIDTH-1] ? (~vdiff + 1'b1) : vdiff;
   assign pv_in = vdb_ff[DATA_WIDTH-1] || (vabs > vdb_ff);
   assign adiff = last_archive_ff - val_c;
   assign aabs  = adiff[DATA_WIDTH-1] ? (~adiff + 1'b1) : adiff;
   assign pa_in = adb_ff[DATA_WIDTH-1] || (aabs > adb_ff);

   assign last_value_in   = pv_in ? val_c : last_value_ff;
   assign last_archive_in = pa_in ? val_c : last_archive_ff;

   // ---------------- state and result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         last_alarm_ff   <= '0;
         last_value_ff   <= '0;
         last_archive_ff <= '0;
         prev_status_ff  <= ST_NONE;
         prev_sev_ff     <= SEV_NONE;
      end else if (s1_move) begin
         last_alarm_ff   <= last_alarm_in;
         last_value_ff   <= last_value_in;
         last_archive_ff <= last_archive_in;
         prev_status_ff  <= stat_in;
         prev_sev_ff     <= sev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_value_ff   <= val_c;
         out_status_ff  <= stat_in;
         out_sev_ff     <= sev_in;
         out_changed_ff <= (stat_in != prev_status_ff) || (sev_in != prev_sev_ff);
         out_pv_ff      <= pv_in;
         out_pa_ff      <= pa_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_output_value       = out_value_ff;
   assign rsp_alarm_status       = out_status_ff;
   assign rsp_alarm_severity     = out_sev_ff;
   assign rsp_alarm_changed      = out_changed_ff;
   assign rsp_post_value_event   = out_pv_ff;
   assign rsp_post_archive_event = out_pa_ff;

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("input stalled with a free stage");

   a_undef_is_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm_status == ST_UNDEF |-> rsp_alarm_severity == SEV_INVALID)
      else $error("undefined alarm without invalid severity");

   a_none_iff_no_sev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_alarm_status == ST_NONE) == (rsp_alarm_severity == SEV_NONE)))
      else $error("alarm status and severity disagree");

   a_history_tracks_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alarm_status == prev_status_ff && rsp_alarm_severity == prev_sev_ff)
      else $error("alarm history out of step with the presented transaction");
`endif

endmodule

`default_nettype wire
